>>> rtl/integral_image_box_sum_defines.svh
// assertion macros for the integral image block
// used by the top level only; expects clk_i and rst_ni in scope
`ifndef INTEGRAL_IMAGE_BOX_SUM_DEFINES_SVH
`define INTEGRAL_IMAGE_BOX_SUM_DEFINES_SVH

// same-cycle implication
`define IIBS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define IIBS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/iibs_pkg.sv
// shared constants for the integral image block
// no dependencies
package iibs_pkg;

  localparam int PIX_W      = 8;
  localparam int OUT_W      = 28;
  localparam int SUM_W      = 29;
  localparam int RECT_W     = 10;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 11;

  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RECT_LEFT    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_RECT_TOP     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_RECT_RIGHT   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_RECT_BOTTOM  = 3'd5;

  localparam logic [CFG_DATA_W-1:0] RST_IMAGE_DIM = 11'd512;
  localparam logic [RECT_W-1:0]     RST_RECT_LO   = 10'd100;
  localparam logic [RECT_W-1:0]     RST_RECT_HI   = 10'd300;

endpackage

>>> rtl/iibs_pix_if.sv
// pixel input channel: valid/ready with one grey pixel
// depends on iibs_pkg
interface iibs_pix_if import iibs_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel;

  modport source (output valid, output pixel, input ready);
  modport sink (input valid, input pixel, output ready);
endinterface

>>> rtl/iibs_res_if.sv
// result channel: integral value and frame-end box sum
// depends on iibs_pkg
interface iibs_res_if import iibs_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [OUT_W-1:0] integral_value;
  logic [OUT_W-1:0] box_sum;
  logic             box_sum_valid;

  modport source (output valid, output integral_value, output box_sum,
                  output box_sum_valid, input ready);
  modport sink (input valid, input integral_value, input box_sum,
                input box_sum_valid, output ready);
endinterface

>>> rtl/iibs_line_store.sv
// previous-row integral store, one write and one registered read port
// no package dependencies
module iibs_line_store #(
  parameter int DEPTH  = 1024,
  parameter int DATA_W = 29
) (
  input  logic                     clk_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [DATA_W-1:0]        rd_data_o,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [DATA_W-1:0]        wr_data_i
);

  logic [DATA_W-1:0] mem_q [DEPTH];
  logic [DATA_W-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

>>> rtl/integral_image_box_sum.sv
// integral image top level: raster pixel in, summed-area value and box sum out
// depends on iibs_pkg, iibs_pix_if, iibs_res_if, iibs_line_store and the defines header
//
// pix_i carries one 8-bit grey pixel per transfer in raster order. res_o gives
// one result per pixel: its integral value, and on the last pixel of a frame
// the sum over the configured rectangle with box_sum_valid high (box_sum is
// zero otherwise). Geometry comes through the cfg write port; the user must
// change it only while no pixel is in flight, as the block does not enforce this.
// Throughput is one pixel per clock while res_o is not stalled. A pixel's result
// passes through the stage 1 register and then the output register: the line
// store read is issued at the input transfer, and the add lands in the output
// register when stage 1 advances.
// A write to the same line store entry as the pending read is forwarded.
// Reset clears the column and row counters, the row sum, the corner latches
// and the pipeline; geometry returns to 512 x 512 with rectangle 100..300.
// The line store needs no clearing: row 0 never uses it.
// When res_o stalls the result is held and the input keeps accepting until
// the internal stage fills, then ready drops until the output moves.
`include "integral_image_box_sum_defines.svh"

module integral_image_box_sum import iibs_pkg::*; #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  iibs_pix_if.sink              pix_i,
  iibs_res_if.source            res_o
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RW = $clog2(MAX_HEIGHT);
  localparam int DW = (CW + 1 > CFG_DATA_W) ? CW + 1 : CFG_DATA_W;
  localparam int HW = (RW + 1 > CFG_DATA_W) ? RW + 1 : CFG_DATA_W;
  localparam int XW = (CW > RECT_W) ? CW : RECT_W;
  localparam int YW = (RW > RECT_W) ? RW : RECT_W;

  typedef struct packed {
    logic first_row;
    logic hit_al;
    logic hit_ar;
    logic hit_bl;
    logic hit_br;
    logic frame_end;
  } s1_ctrl_t;

  // configuration
  logic [CFG_DATA_W-1:0] width_q, height_q;
  logic [RECT_W-1:0]     left_q, top_q, right_q, bottom_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= RST_IMAGE_DIM;
      height_q <= RST_IMAGE_DIM;
      left_q   <= RST_RECT_LO;
      top_q    <= RST_RECT_LO;
      right_q  <= RST_RECT_HI;
      bottom_q <= RST_RECT_HI;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_IMAGE_WIDTH:  width_q  <= cfg_wdata_i;
        CFG_IMAGE_HEIGHT: height_q <= cfg_wdata_i;
        CFG_RECT_LEFT:    left_q   <= cfg_wdata_i[RECT_W-1:0];
        CFG_RECT_TOP:     top_q    <= cfg_wdata_i[RECT_W-1:0];
        CFG_RECT_RIGHT:   right_q  <= cfg_wdata_i[RECT_W-1:0];
        CFG_RECT_BOTTOM:  bottom_q <= cfg_wdata_i[RECT_W-1:0];
        default: ;
      endcase
    end
  end

  // stage 0: counters, running row sum, corner match
  logic [CW-1:0]    col_q, col_d;
  logic [RW-1:0]    row_q, row_d;
  logic [SUM_W-1:0] rs_q, rs_d;
  logic             in_acc;
  logic [DW-1:0]    w_ext, w_cl, last_col;
  logic [HW-1:0]    h_ext, h_cl, last_row;
  logic             row_end, frame_end;
  logic [XW-1:0]    col_x, left_x, left_m1, right_x;
  logic [YW-1:0]    row_y, top_y, top_m1, bot_y;
  s1_ctrl_t         ctrl_d;

  assign w_ext    = DW'(width_q);
  assign w_cl     = (w_ext == '0) ? DW'(1) :
                    (w_ext > DW'(MAX_WIDTH)) ? DW'(MAX_WIDTH) : w_ext;
  assign last_col = w_cl - DW'(1);
  assign h_ext    = HW'(height_q);
  assign h_cl     = (h_ext == '0) ? HW'(1) :
                    (h_ext > HW'(MAX_HEIGHT)) ? HW'(MAX_HEIGHT) : h_ext;
  assign last_row = h_cl - HW'(1);

  assign row_end   = DW'(col_q) >= last_col;
  assign frame_end = row_end && (HW'(row_q) >= last_row);

  assign col_x   = XW'(col_q);
  assign left_x  = XW'(left_q);
  assign left_m1 = left_x - XW'(1);
  assign right_x = XW'(right_q);
  assign row_y   = YW'(row_q);
  assign top_y   = YW'(top_q);
  assign top_m1  = top_y - YW'(1);
  assign bot_y   = YW'(bottom_q);

  always_comb begin
    ctrl_d.first_row = (row_q == '0);
    ctrl_d.hit_al    = (top_q != '0) && (left_q != '0) && (row_y == top_m1) &&
                       (col_x == left_m1);
    ctrl_d.hit_ar    = (top_q != '0) && (row_y == top_m1) && (col_x == right_x);
    ctrl_d.hit_bl    = (left_q != '0) && (row_y == bot_y) && (col_x == left_m1);
    ctrl_d.hit_br    = (row_y == bot_y) && (col_x == right_x);
    ctrl_d.frame_end = frame_end;
  end

  assign rs_d  = ((col_q == '0) ? '0 : rs_q) + SUM_W'(pix_i.pixel);
  assign col_d = row_end ? '0 : col_q + CW'(1);
  assign row_d = frame_end ? '0 : (row_end ? row_q + RW'(1) : row_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
      rs_q  <= '0;
    end else if (in_acc) begin
      col_q <= col_d;
      row_q <= row_d;
      rs_q  <= rs_d;
    end
  end

  // stage 1: add the row above, latch corners
  logic             s1_valid_q, s1_adv;
  s1_ctrl_t         s1_ctrl_q;
  logic [CW-1:0]    s1_col_q;
  logic [SUM_W-1:0] s1_rs_q;
  logic             fwd_q;
  logic [SUM_W-1:0] fwd_data_q;
  logic [SUM_W-1:0] rd_data, above, integ;
  logic [SUM_W-1:0] al_q, ar_q, bl_q, br_q;
  logic [SUM_W-1:0] al_n, ar_n, bl_n, br_n, box;

  assign s1_adv      = s1_valid_q && (!res_o.valid || res_o.ready);
  assign pix_i.ready = !s1_valid_q || s1_adv;
  assign in_acc      = pix_i.valid && pix_i.ready;

  iibs_line_store #(
    .DEPTH  (MAX_WIDTH),
    .DATA_W (SUM_W)
  ) u_line_store (
    .clk_i     (clk_i),
    .rd_en_i   (in_acc),
    .rd_addr_i (col_q),
    .rd_data_o (rd_data),
    .wr_en_i   (s1_adv),
    .wr_addr_i (s1_col_q),
    .wr_data_i (integ)
  );

  assign above = s1_ctrl_q.first_row ? '0 : (fwd_q ? fwd_data_q : rd_data);
  assign integ = above + s1_rs_q;

  assign al_n = s1_ctrl_q.hit_al ? integ : al_q;
  assign ar_n = s1_ctrl_q.hit_ar ? integ : ar_q;
  assign bl_n = s1_ctrl_q.hit_bl ? integ : bl_q;
  assign br_n = s1_ctrl_q.hit_br ? integ : br_q;
  assign box  = br_n - bl_n - ar_n + al_n;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s1_ctrl_q  <= '0;
      fwd_q      <= 1'b0;
    end else if (in_acc) begin
      s1_valid_q <= 1'b1;
      s1_ctrl_q  <= ctrl_d;
      fwd_q      <= s1_adv && (s1_col_q == col_q);
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
      fwd_q      <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_col_q   <= col_q;
      s1_rs_q    <= rs_d;
      fwd_data_q <= integ;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      al_q <= '0;
      ar_q <= '0;
      bl_q <= '0;
      br_q <= '0;
    end else if (s1_adv) begin
      if (s1_ctrl_q.frame_end) begin
        al_q <= '0;
        ar_q <= '0;
        bl_q <= '0;
        br_q <= '0;
      end else begin
        al_q <= al_n;
        ar_q <= ar_n;
        bl_q <= bl_n;
        br_q <= br_n;
      end
    end
  end

  // output register
  logic             out_valid_q;
  logic [OUT_W-1:0] out_integ_q, out_box_q;
  logic             out_box_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv) begin
      out_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_integ_q     <= integ[OUT_W-1:0];
      out_box_q       <= s1_ctrl_q.frame_end ? box[OUT_W-1:0] : '0;
      out_box_valid_q <= s1_ctrl_q.frame_end;
    end
  end

  assign res_o.valid          = out_valid_q;
  assign res_o.integral_value = out_integ_q;
  assign res_o.box_sum        = out_box_q;
  assign res_o.box_sum_valid  = out_box_valid_q;

  `IIBS_ASSERT_IMP(a_box_zero, res_o.valid && !res_o.box_sum_valid,
                   res_o.box_sum == '0, "box sum not zero off frame end")
  `IIBS_ASSERT_NXT(a_s1_hold, s1_valid_q && !s1_adv && !in_acc,
                   s1_valid_q && (s1_col_q == $past(s1_col_q)),
                   "stage 1 lost a stalled pixel")
  `IIBS_ASSERT_NXT(a_col_step, in_acc && !row_end,
                   col_q == CW'($past(col_q) + 1'b1), "column counter skipped")
  `IIBS_ASSERT_IMP(a_fwd_valid, fwd_q, s1_valid_q,
                   "forward flag without a pixel in stage 1")

endmodule

>>> tb/integral_image_checker.sv
`timescale 1ns / 100ps
// checker for the integral image block: watches the geometry writes and both channels,
// predicts each summed-area value and frame-end box sum, and compares in order
// depends on iibs_pkg, iibs_pix_if and iibs_res_if
module integral_image_checker import iibs_pkg::*; #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  iibs_pix_if                   pix_i,
  iibs_res_if                   res_i,
  output int                    fail_count_o,
  output int                    pending_o,
  output int                    box_sums_o
);

  typedef struct packed {
    logic [OUT_W-1:0] integral_value;
    logic [OUT_W-1:0] box_sum;
    logic             box_sum_valid;
  } sat_result_t;

  logic [CFG_DATA_W-1:0] width_q;
  logic [CFG_DATA_W-1:0] height_q;
  logic [RECT_W-1:0]     left_q;
  logic [RECT_W-1:0]     top_q;
  logic [RECT_W-1:0]     right_q;
  logic [RECT_W-1:0]     bottom_q;

  logic [SUM_W-1:0] line_sums [MAX_WIDTH];
  logic [SUM_W-1:0] row_sum;
  int               col_q;
  int               row_q;
  logic [SUM_W-1:0] above_left;
  logic [SUM_W-1:0] above_right;
  logic [SUM_W-1:0] below_left;
  logic [SUM_W-1:0] below_right;

  sat_result_t expected_sat_q [$];
  sat_result_t expected;
  int          fail_count = 0;
  int          pending = 0;
  int          box_sums = 0;

  assign fail_count_o = fail_count;
  assign pending_o    = pending;
  assign box_sums_o   = box_sums;

  function automatic int effective_dim(int value, int limit);
    if (value == 0) return 1;
    if (value > limit) return limit;
    return value;
  endfunction

  // advances the raster position by one pixel and returns its result
  function automatic sat_result_t next_summed_area(logic [PIX_W-1:0] pixel);
    sat_result_t      r;
    int               w;
    int               h;
    int               col;
    int               row;
    logic [SUM_W-1:0] above;
    logic [SUM_W-1:0] integ;
    logic             row_end;
    logic             frame_end;
    w = effective_dim(int'(width_q), MAX_WIDTH);
    h = effective_dim(int'(height_q), MAX_HEIGHT);
    col = col_q;
    row = row_q;
    if (col == 0) row_sum = '0;
    row_sum = row_sum + SUM_W'(pixel);
    above = (row == 0 || col >= MAX_WIDTH) ? '0 : line_sums[col];
    integ = above + row_sum;
    if (col < MAX_WIDTH) line_sums[col] = integ;
    // a corner row or column of -1 never matches
    if (row == int'(top_q) - 1 && col == int'(left_q) - 1) above_left = integ;
    if (row == int'(top_q) - 1 && col == int'(right_q)) above_right = integ;
    if (row == int'(bottom_q) && col == int'(left_q) - 1) below_left = integ;
    if (row == int'(bottom_q) && col == int'(right_q)) below_right = integ;
    row_end = (col >= w - 1);
    frame_end = row_end && (row >= h - 1);
    r.integral_value = integ[OUT_W-1:0];
    r.box_sum = '0;
    r.box_sum_valid = frame_end;
    if (frame_end) begin
      r.box_sum = OUT_W'(below_right - below_left - above_right + above_left);
      above_left = '0;
      above_right = '0;
      below_left = '0;
      below_right = '0;
      col_q = 0;
      row_q = 0;
    end else if (row_end) begin
      col_q = 0;
      row_q = row + 1;
    end else begin
      col_q = col + 1;
    end
    return r;
  endfunction

  task automatic report_mismatch(input string field, input logic [OUT_W-1:0] exp_value,
                                 input logic [OUT_W-1:0] act_value);
    fail_count++;
    $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, exp_value,
             act_value);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q = RST_IMAGE_DIM;
      height_q = RST_IMAGE_DIM;
      left_q = RST_RECT_LO;
      top_q = RST_RECT_LO;
      right_q = RST_RECT_HI;
      bottom_q = RST_RECT_HI;
      row_sum = '0;
      col_q = 0;
      row_q = 0;
      above_left = '0;
      above_right = '0;
      below_left = '0;
      below_right = '0;
      expected_sat_q.delete();
      pending = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_IMAGE_WIDTH: width_q = cfg_wdata_i;
          CFG_IMAGE_HEIGHT: height_q = cfg_wdata_i;
          CFG_RECT_LEFT: left_q = cfg_wdata_i[RECT_W-1:0];
          CFG_RECT_TOP: top_q = cfg_wdata_i[RECT_W-1:0];
          CFG_RECT_RIGHT: right_q = cfg_wdata_i[RECT_W-1:0];
          CFG_RECT_BOTTOM: bottom_q = cfg_wdata_i[RECT_W-1:0];
          default: ;
        endcase
      end
      if (pix_i.valid && pix_i.ready) begin
        expected_sat_q.push_back(next_summed_area(pix_i.pixel));
      end
      if (res_i.valid && res_i.ready) begin
        if (expected_sat_q.size() == 0) begin
          fail_count++;
          $display("%0t: result transfer with nothing expected, actual integral %0d",
                   $time, res_i.integral_value);
        end else begin
          expected = expected_sat_q.pop_front();
          if (res_i.integral_value !== expected.integral_value) begin
            report_mismatch("integral_value", expected.integral_value,
                            res_i.integral_value);
          end
          if (res_i.box_sum !== expected.box_sum) begin
            report_mismatch("box_sum", expected.box_sum, res_i.box_sum);
          end
          if (res_i.box_sum_valid !== expected.box_sum_valid) begin
            report_mismatch("box_sum_valid", OUT_W'(expected.box_sum_valid),
                            OUT_W'(res_i.box_sum_valid));
          end
          if (expected.box_sum_valid) box_sums++;
        end
      end
      pending = expected_sat_q.size();
    end
  end

endmodule

>>> tb/testbench.sv
`timescale 1ns / 100ps
// top of the integral image testbench: clock, reset, geometry writes, pixel stimulus,
// output back-pressure and the verdict; checking is done by integral_image_checker
// depends on iibs_pkg, iibs_pix_if, iibs_res_if, integral_image_box_sum and the checker
module testbench;
  import iibs_pkg::*;

  localparam int MAX_WIDTH       = 1024;
  localparam int MAX_HEIGHT      = 1024;
  localparam int RANDOM_ITEMS    = 360;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int SETTLE_CYCLES   = 4;
  localparam int TIMEOUT_NS      = 2_000_000;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata_i = '0;

  int fail_count;
  int pending;
  int box_sums;

  int send_idle_pct = 32;
  int recv_idle_pct = 77;
  int hold_offs_requested = 0;
  int hold_offs_done = 0;

  int   geom_w;
  int   geom_h;
  int   pos_col = 0;
  int   pos_row = 0;
  logic frame_done = 1'b0;
  int   pixels_sent = 0;
  int   geometry_writes = 0;

  iibs_pix_if pix_if ();
  iibs_res_if res_if ();

  integral_image_box_sum #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .pix_i      (pix_if),
    .res_o      (res_if)
  );

  integral_image_checker #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT)
  ) sat_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .pix_i       (pix_if),
    .res_i       (res_if),
    .fail_count_o(fail_count),
    .pending_o   (pending),
    .box_sums_o  (box_sums)
  );

  always #2 clk_i = ~clk_i;

  initial begin
    #(TIMEOUT_NS);
    $display("Verification failed");
    $finish;
  end

  // output back-pressure, with a long hold-off whenever one is requested
  initial begin
    res_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_offs_requested != hold_offs_done) begin
        res_if.ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(negedge clk_i);
        hold_offs_done++;
      end
      res_if.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  function automatic logic [PIX_W-1:0] random_pixel();
    case ($urandom_range(7))
      0: return '0;
      1: return '1;
      default: return PIX_W'($urandom_range(255));
    endcase
  endfunction

  function automatic int random_rect(int span);
    if ($urandom_range(3) == 0) return $urandom_range(1023);
    return $urandom_range(span);
  endfunction

  task automatic wait_idle();
    pix_if.valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= CFG_DATA_W'(value);
    @(negedge clk_i);
  endtask

  task automatic write_geometry(input int w, input int h, input int l, input int t,
                                input int r, input int b);
    wait_idle();
    write_reg(CFG_IMAGE_WIDTH, w);
    write_reg(CFG_IMAGE_HEIGHT, h);
    write_reg(CFG_RECT_LEFT, l);
    write_reg(CFG_RECT_TOP, t);
    write_reg(CFG_RECT_RIGHT, r);
    write_reg(CFG_RECT_BOTTOM, b);
    cfg_we_i <= 1'b0;
    geom_w = (w == 0) ? 1 : ((w > MAX_WIDTH) ? MAX_WIDTH : w);
    geom_h = (h == 0) ? 1 : ((h > MAX_HEIGHT) ? MAX_HEIGHT : h);
    geometry_writes++;
  endtask

  // entered and left at a falling edge
  task automatic send_pixel(input logic [PIX_W-1:0] value);
    logic row_end;
    while ($urandom_range(99) < send_idle_pct) begin
      pix_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    pix_if.valid <= 1'b1;
    pix_if.pixel <= value;
    do @(posedge clk_i); while (!pix_if.ready);
    @(negedge clk_i);
    pixels_sent++;
    row_end = (pos_col >= geom_w - 1);
    frame_done = row_end && (pos_row >= geom_h - 1);
    if (frame_done) begin
      pos_col = 0;
      pos_row = 0;
    end else if (row_end) begin
      pos_col = 0;
      pos_row++;
    end else begin
      pos_col++;
    end
  endtask

  task automatic send_frame_rest();
    do send_pixel(random_pixel()); while (!frame_done);
  endtask

  task automatic random_frame();
    int w;
    int h;
    int cut;
    w = ($urandom_range(19) == 0) ? 0 : $urandom_range(1, 16);
    h = ($urandom_range(19) == 0) ? 0 : $urandom_range(1, 12);
    write_geometry(w, h, random_rect(w), random_rect(h), random_rect(w), random_rect(h));
    if ($urandom_range(7) == 0 && geom_w * geom_h > 1) begin
      // geometry change in the middle of a frame
      cut = $urandom_range(1, geom_w * geom_h - 1);
      repeat (cut) send_pixel(random_pixel());
      w = $urandom_range(1, 16);
      h = $urandom_range(1, 12);
      write_geometry(w, h, random_rect(w), random_rect(h), random_rect(w), random_rect(h));
    end
    send_frame_rest();
  endtask

  task automatic random_phase(input int send_pct, input int recv_pct, input logic pressure);
    int stop_at;
    send_idle_pct = send_pct;
    recv_idle_pct <= recv_pct;
    stop_at = pixels_sent + RANDOM_ITEMS / 3;
    if (pressure) begin
      write_geometry(16, 8, random_rect(16), random_rect(8), random_rect(16), random_rect(8));
      hold_offs_requested <= hold_offs_requested + 1;
      send_frame_rest();
    end
    while (pixels_sent < stop_at) random_frame();
  endtask

  initial begin
    logic [PIX_W-1:0] pattern [9];
    pattern = '{8'd255, 8'd0, 8'd255, 8'd1, 8'd2, 8'd4, 8'd255, 8'd255, 8'd255};
    pix_if.valid = 1'b0;
    pix_if.pixel = '0;
    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // single-pixel frames, zero geometry acting as one
    write_geometry(1, 1, 0, 0, 0, 0);
    send_pixel(8'd255);
    send_pixel(8'd0);
    write_geometry(0, 0, 0, 0, 0, 0);
    send_pixel(8'h80);
    // all four corners inside the image
    write_geometry(3, 3, 1, 1, 2, 2);
    foreach (pattern[i]) send_pixel(pattern[i]);
    // inverted rectangle
    write_geometry(2, 2, 1, 1, 0, 0);
    repeat (4) send_pixel(8'd255);
    // corners the frame never reaches
    write_geometry(3, 2, 0, 0, 1023, 1023);
    repeat (6) send_pixel(8'd255);

    // oversized width clamps; the full-width row also fills the line store
    write_geometry(2047, 1, 0, 0, 1023, 0);
    send_frame_rest();

    random_phase(32, 77, 1'b0);
    random_phase(77, 32, 1'b0);
    random_phase(0, 0, 1'b1);

    wait_idle();
    repeat (8) @(negedge clk_i);
    $display("Run covered %0d pixel transfers over %0d geometry settings, %0d box sums checked",
             pixels_sent, geometry_writes, box_sums);
    $display("including clamped and mid-frame geometry and a %0d-cycle output hold-off",
             HOLD_OFF_CYCLES);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
